// ===== hdl/hsl2rgb_pkg.sv =====
`default_nettype none

package hsl2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    // signed working width for q, p and their differences
    localparam int SW        = VAL_W + 3;
    // width of the lightness product
    localparam int QPROD_W   = 2 * VAL_W + 1;
    // width of the channel ramp product
    localparam int CPROD_W   = 2 * VAL_W;

    localparam logic [VAL_W-1:0] ONE   = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] HALF  = VAL_W'(1) << (FRAC_BITS - 1);
    localparam logic [VAL_W-1:0] THIRD = VAL_W'(((2 ** FRAC_BITS) + 1) / 3);

    typedef struct packed {
        logic [VAL_W-1:0] hue;
        logic [VAL_W-1:0] saturation;
        logic [VAL_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
    } rgb_t;

    // piece of the hue function a channel falls in
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } seg_t;

    typedef struct packed {
        seg_t             seg;
        logic [VAL_W-1:0] factor;
    } chan_t;

    function automatic logic [VAL_W-1:0] sat_in(input logic [VAL_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic logic [VAL_W-1:0] clamp_unit(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] one_s;
        one_s = signed'(SW'(ONE));
        if (v < 0) begin
            return '0;
        end else if (v > one_s) begin
            return ONE;
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

    // segment and ramp factor for a wrapped hue t in 0..ONE
    function automatic chan_t hue_setup(input logic [VAL_W-1:0] t);
        logic [SW-1:0] six_t;
        logic [SW-1:0] three_t;
        chan_t         c;
        six_t   = (SW'(t) << 2) + (SW'(t) << 1);
        three_t = (SW'(t) << 1) + SW'(t);
        c.factor = '0;
        if (six_t < SW'(ONE)) begin
            c.seg    = SEG_RISE;
            c.factor = six_t[VAL_W-1:0];
        end else if (t < HALF) begin
            c.seg = SEG_HIGH;
        end else if (three_t < (SW'(ONE) << 1)) begin
            c.seg    = SEG_FALL;
            c.factor = VAL_W'((SW'(ONE) << 2) - six_t);
        end else begin
            c.seg = SEG_LOW;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hsl2rgb_front.sv =====
`default_nettype none

// stages 1 and 2: input saturation, hue offsets, q/p/d
module hsl2rgb_front (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire hsl2rgb_pkg::hsl_t             hsl,
    output hsl2rgb_pkg::chan_t                 red_set,
    output hsl2rgb_pkg::chan_t                 green_set,
    output hsl2rgb_pkg::chan_t                 blue_set,
    output logic [hsl2rgb_pkg::VAL_W-1:0]      q,
    output logic [hsl2rgb_pkg::VAL_W-1:0]      p,
    output logic [hsl2rgb_pkg::VAL_W-1:0]      d
);

    localparam int VW = hsl2rgb_pkg::VAL_W;
    localparam int SW = hsl2rgb_pkg::SW;
    localparam int QW = hsl2rgb_pkg::QPROD_W;

    // stage 1
    logic [VW-1:0] h, s, l;
    logic [VW:0]   t_r_sum;
    logic [VW-1:0] t_r, t_b;
    logic [VW:0]   mult_b;
    logic          lo;

    hsl2rgb_pkg::chan_t r1_reg, r1_next, g1_reg, g1_next, b1_reg, b1_next;
    logic [QW-1:0] prod_reg, prod_next;
    logic [VW-1:0] l_reg, s_reg;
    logic          lo_reg;

    always_comb begin
        h  = hsl2rgb_pkg::sat_in(hsl.hue);
        s  = hsl2rgb_pkg::sat_in(hsl.saturation);
        l  = hsl2rgb_pkg::sat_in(hsl.lightness);
        lo = (l < hsl2rgb_pkg::HALF);

        t_r_sum = (VW+1)'(h) + (VW+1)'(hsl2rgb_pkg::THIRD);
        if (t_r_sum > (VW+1)'(hsl2rgb_pkg::ONE)) begin
            t_r = VW'(t_r_sum - (VW+1)'(hsl2rgb_pkg::ONE));
        end else begin
            t_r = VW'(t_r_sum);
        end
        if (h < hsl2rgb_pkg::THIRD) begin
            t_b = h + hsl2rgb_pkg::ONE - hsl2rgb_pkg::THIRD;
        end else begin
            t_b = h - hsl2rgb_pkg::THIRD;
        end

        r1_next = hsl2rgb_pkg::hue_setup(t_r);
        g1_next = hsl2rgb_pkg::hue_setup(h);
        b1_next = hsl2rgb_pkg::hue_setup(t_b);

        // l*(1+s) below half lightness, l*s above
        mult_b    = lo ? ((VW+1)'(hsl2rgb_pkg::ONE) + (VW+1)'(s)) : (VW+1)'(s);
        prod_next = QW'(l) * QW'(mult_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= r1_next;
            g1_reg   <= g1_next;
            b1_reg   <= b1_next;
            prod_reg <= prod_next;
            l_reg    <= l;
            s_reg    <= s;
            lo_reg   <= lo;
        end
    end

    // stage 2
    logic [SW-1:0]        rnd;
    logic signed [SW-1:0] q_raw, p_raw;
    logic [VW-1:0]        q_next, p_next, d_next;
    logic [VW-1:0]        q_reg, p_reg, d_reg;
    hsl2rgb_pkg::chan_t   r2_reg, g2_reg, b2_reg;

    always_comb begin
        rnd = SW'((prod_reg + QW'(hsl2rgb_pkg::HALF)) >> hsl2rgb_pkg::FRAC_BITS);
        if (lo_reg) begin
            q_raw = signed'(rnd);
        end else begin
            q_raw = signed'(SW'(l_reg) + SW'(s_reg) - rnd);
        end
        q_next = hsl2rgb_pkg::clamp_unit(q_raw);
        p_raw  = signed'(SW'(l_reg) << 1) - signed'(SW'(q_next));
        p_next = hsl2rgb_pkg::clamp_unit(p_raw);
        d_next = (q_next > p_next) ? (q_next - p_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg  <= q_next;
            p_reg  <= p_next;
            d_reg  <= d_next;
            r2_reg <= r1_reg;
            g2_reg <= g1_reg;
            b2_reg <= b1_reg;
        end
    end

    assign q         = q_reg;
    assign p         = p_reg;
    assign d         = d_reg;
    assign red_set   = r2_reg;
    assign green_set = g2_reg;
    assign blue_set  = b2_reg;

endmodule

`default_nettype wire

// ===== hdl/hsl2rgb_chan.sv =====
`default_nettype none

// stages 3 and 4 of one color channel: ramp product, round, add, clamp
module hsl2rgb_chan (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire hsl2rgb_pkg::chan_t            set,
    input  wire logic [hsl2rgb_pkg::VAL_W-1:0] q,
    input  wire logic [hsl2rgb_pkg::VAL_W-1:0] p,
    input  wire logic [hsl2rgb_pkg::VAL_W-1:0] d,
    output logic [hsl2rgb_pkg::VAL_W-1:0]      value
);

    localparam int VW = hsl2rgb_pkg::VAL_W;
    localparam int SW = hsl2rgb_pkg::SW;
    localparam int CW = hsl2rgb_pkg::CPROD_W;

    // stage 3
    logic [CW-1:0]     prod_reg;
    logic [VW-1:0]     q_reg, p_reg;
    hsl2rgb_pkg::seg_t seg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= CW'(d) * CW'(set.factor);
            q_reg    <= q;
            p_reg    <= p;
            seg_reg  <= set.seg;
        end
    end

    // stage 4
    logic [SW-1:0] ramp;
    logic [VW-1:0] value_next, value_reg;

    always_comb begin
        ramp = SW'((prod_reg + CW'(hsl2rgb_pkg::HALF)) >> hsl2rgb_pkg::FRAC_BITS)
             + SW'(p_reg);
        case (seg_reg)
            hsl2rgb_pkg::SEG_RISE,
            hsl2rgb_pkg::SEG_FALL: value_next = hsl2rgb_pkg::clamp_unit(signed'(ramp));
            hsl2rgb_pkg::SEG_HIGH: value_next = q_reg;
            hsl2rgb_pkg::SEG_LOW:  value_next = p_reg;
            default:               value_next = p_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/hsl_to_rgb_converter.sv =====
`default_nettype none

//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_data : hsl_t (hue, saturation, lightness)
//  m_       out        m_valid/m_ready    m_data : rgb_t (red, green, blue)
//
//  one request per cycle sustained while the output is not stalled; four register
//  stages (input stage, q/p stage, ramp multiply, output register); m_valid is the
//  stage valid bit of the output register
//  the depth follows the multipliers: l*s or l*(1+s), then d*factor per channel
//  reset (aresetn, synchronous) clears only the stage valid bits
//  a stall on m_ready freezes the whole pipeline; s_ready drops only while the
//  output register holds a request and m_ready is low, bubbles stay in place
module hsl_to_rgb_converter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hsl2rgb_pkg::hsl_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hsl2rgb_pkg::rgb_t      m_data
);

    localparam int VW = hsl2rgb_pkg::VAL_W;

    // pipeline advances whenever the output slot is free or being taken
    logic en;
    // valid bits of the four stages; the last one is the output register
    logic [3:0] vld_reg, vld_next;

    hsl2rgb_pkg::chan_t red_set, green_set, blue_set;
    logic [VW-1:0]      q, p, d;
    logic [VW-1:0]      red, green, blue;

    assign en      = !vld_reg[3] || m_ready;
    assign s_ready = en;

    // the valid bits shift along with the data under the same enable
    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // shared front: saturate inputs, form q, p and q-p, pick each hue segment
    hsl2rgb_front u_front (
        .aclk      (aclk),
        .en        (en),
        .hsl       (s_data),
        .red_set   (red_set),
        .green_set (green_set),
        .blue_set  (blue_set),
        .q         (q),
        .p         (p),
        .d         (d)
    );

    // one ramp unit per channel
    hsl2rgb_chan u_red (
        .aclk  (aclk),
        .en    (en),
        .set   (red_set),
        .q     (q),
        .p     (p),
        .d     (d),
        .value (red)
    );

    hsl2rgb_chan u_green (
        .aclk  (aclk),
        .en    (en),
        .set   (green_set),
        .q     (q),
        .p     (p),
        .d     (d),
        .value (green)
    );

    hsl2rgb_chan u_blue (
        .aclk  (aclk),
        .en    (en),
        .set   (blue_set),
        .q     (q),
        .p     (p),
        .d     (d),
        .value (blue)
    );

    assign m_valid      = vld_reg[3];
    assign m_data.red   = red;
    assign m_data.green = green;
    assign m_data.blue  = blue;

endmodule

`default_nettype wire
